FILE: hdl/hse_pkg.sv
`default_nettype none

package hse_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int POS_FRAC    = 16;
    localparam int POS_W       = 17;
    localparam int SLOPE_LIMIT = 21;

    localparam int VAL_W    = 32;
    localparam int SPAN_W   = 31;
    localparam int SLOPE_W  = 22;
    localparam int SLC_W    = (FRAC_BITS + 6 > SLOPE_W) ? FRAC_BITS + 6 : SLOPE_W;
    localparam int MPROD_W  = SPAN_W + 1 + SLC_W;

    // Largest magnitude anywhere in the Horner chain stays below 2^40.
    localparam int ACC_W    = 42;

    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1 << POS_FRAC);
    localparam logic signed [SLC_W-1:0] SLOPE_MAX = SLC_W'(SLOPE_LIMIT * (2 ** FRAC_BITS));
    localparam logic signed [SLC_W-1:0] SLOPE_MIN = -SLOPE_MAX;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [SLC_W-1:0] t_slope;

    localparam t_acc VAL_MAX = t_acc'(64'sd2147483647);
    localparam t_acc VAL_MIN = t_acc'(-64'sd2147483648);

    function automatic t_val sat_val(input t_acc x);
        t_val r;
        if (x > VAL_MAX) begin
            r = t_val'(VAL_MAX);
        end else if (x < VAL_MIN) begin
            r = t_val'(VAL_MIN);
        end else begin
            r = x[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/hse_horner_step.sv
`default_nettype none

// One Horner step: floor(acc * t / 2^16) + addend, registered.
module hse_horner_step (
    input  wire logic                      i_clk,
    input  wire hse_pkg::t_acc             i_acc,
    input  wire logic [hse_pkg::POS_W-1:0] i_pos,
    input  wire hse_pkg::t_acc             i_add,
    output hse_pkg::t_acc                  o_acc
);
    import hse_pkg::*;

    logic signed [ACC_W+POS_W:0] prod;
    logic signed [ACC_W+POS_W:0] prod_sh;
    t_acc                        n_acc;
    t_acc                        r_acc;

    always_comb begin
        prod    = i_acc * $signed({1'b0, i_pos});
        prod_sh = prod >>> POS_FRAC;
        n_acc   = prod_sh[ACC_W-1:0] + i_add;
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

FILE: hdl/hermite_segment_evaluate_core.sv
// Cubic Hermite segment evaluator.
// Input channel: an item transfers on a rising edge with start high and busy
// low. busy is always low, so a new segment can be issued every clock.
// Each item carries both key values, the span, the two key slopes, a step
// flag and the position t (Q1.16, values above 1.0 saturate to 1.0).
// Output channel: o_done is high for exactly one cycle with o_curve_value
// and o_curve_slope; the transfer completes at the edge ending that cycle.
// The receiver cannot stall, so results never wait.
// Throughput: one item per cycle, set by the seven-stage pipeline (input
// clamp, span multiply, coefficients, three Horner multiply-add steps,
// saturation), no path in a stage passing more than one multiplier.
// Reset (synchronous, active low) clears the valid bits; items in flight
// are dropped and no strobe appears until new items are issued.
`default_nettype none

module hermite_segment_evaluate_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [31:0]            i_start_value,
    input  wire logic signed [31:0]            i_end_value,
    input  wire logic [30:0]                   i_seg_span,
    input  wire logic signed [21:0]            i_out_slope,
    input  wire logic signed [21:0]            i_in_slope,
    input  wire logic                          i_step_mode,
    input  wire logic [16:0]                   i_position,
    output logic                               o_done,
    output logic signed [31:0]                 o_curve_value,
    output logic signed [31:0]                 o_curve_slope
);
    import hse_pkg::*;

    localparam int STAGES = 7;

    // Valid bit per stage, travels with the data.
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;

    // Stage 1: captured inputs, slopes clamped, position saturated.
    t_val              r1_p0, r1_p1;
    logic [SPAN_W-1:0] r1_span;
    t_slope            r1_s0, r1_s1;
    logic              r1_step;
    logic [POS_W-1:0]  r1_pos;
    t_slope            n1_s0, n1_s1, s0_ext, s1_ext;
    logic [POS_W-1:0]  n1_pos;

    // Stage 2: scaled tangents.
    t_val                      r2_p0, r2_p1;
    logic                      r2_step;
    logic [POS_W-1:0]          r2_pos;
    t_acc                      r2_m0, r2_m1;
    logic signed [MPROD_W-1:0] prod0, prod1, prod0_sh, prod1_sh;

    // Stage 3: coefficients for value and derivative.
    t_acc             r3_c0, r3_c1, r3_c2, r3_c3, r3_d0, r3_d1;
    t_acc             n3_c0, n3_c1, n3_d0, n3_d1;
    t_acc             p0e, p1e;
    logic [POS_W-1:0] r3_pos;

    // Horner stages.
    t_acc             acc1, acc2, acc3, der1, der2;
    t_acc             r4_c2, r4_c3, r5_c3, r6_der;
    logic [POS_W-1:0] r4_pos, r5_pos;

    // Output register.
    t_val r7_value, r7_slope;

    assign busy = 1'b0;

    always_comb begin
        n_vld = {r_vld[STAGES-2:0], start & ~busy};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage 1: clamp slopes to +/- the limit, hold t at 1.0 at most.
    always_comb begin
        s0_ext = SLC_W'(i_out_slope);
        s1_ext = SLC_W'(i_in_slope);
        if (s0_ext > SLOPE_MAX) begin
            n1_s0 = SLOPE_MAX;
        end else if (s0_ext < SLOPE_MIN) begin
            n1_s0 = SLOPE_MIN;
        end else begin
            n1_s0 = s0_ext;
        end
        if (s1_ext > SLOPE_MAX) begin
            n1_s1 = SLOPE_MAX;
        end else if (s1_ext < SLOPE_MIN) begin
            n1_s1 = SLOPE_MIN;
        end else begin
            n1_s1 = s1_ext;
        end
        n1_pos = (i_position > POS_ONE) ? POS_ONE : i_position;
    end

    always_ff @(posedge i_clk) begin
        r1_p0   <= i_start_value;
        r1_p1   <= i_end_value;
        r1_span <= i_seg_span;
        r1_s0   <= n1_s0;
        r1_s1   <= n1_s1;
        r1_step <= i_step_mode;
        r1_pos  <= n1_pos;
    end

    // Stage 2: m = floor(span * slope / 2^FRAC_BITS), both tangents in parallel.
    always_comb begin
        prod0    = $signed({1'b0, r1_span}) * r1_s0;
        prod1    = $signed({1'b0, r1_span}) * r1_s1;
        prod0_sh = prod0 >>> FRAC_BITS;
        prod1_sh = prod1 >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        r2_p0   <= r1_p0;
        r2_p1   <= r1_p1;
        r2_step <= r1_step;
        r2_pos  <= r1_pos;
        r2_m0   <= prod0_sh[ACC_W-1:0];
        r2_m1   <= prod1_sh[ACC_W-1:0];
    end

    // Stage 3: Hermite coefficients. The derivative chain takes 3*c0 and
    // 2*c1, each formed straight from the keys so none waits on c0 or c1.
    // Step mode zeroes everything but the constant term.
    always_comb begin
        p0e   = ACC_W'(r2_p0);
        p1e   = ACC_W'(r2_p1);
        n3_c0 = (p0e <<< 1) - (p1e <<< 1) + r2_m0 + r2_m1;
        n3_c1 = (p1e <<< 1) + p1e - (p0e <<< 1) - p0e - (r2_m0 <<< 1) - r2_m1;
        n3_d0 = (p0e <<< 2) + (p0e <<< 1) - (p1e <<< 2) - (p1e <<< 1)
              + (r2_m0 <<< 1) + r2_m0 + (r2_m1 <<< 1) + r2_m1;
        n3_d1 = (p1e <<< 2) + (p1e <<< 1) - (p0e <<< 2) - (p0e <<< 1)
              - (r2_m0 <<< 2) - (r2_m1 <<< 1);
    end

    always_ff @(posedge i_clk) begin
        r3_c0  <= r2_step ? '0 : n3_c0;
        r3_c1  <= r2_step ? '0 : n3_c1;
        r3_c2  <= r2_step ? '0 : r2_m0;
        r3_c3  <= p0e;
        r3_d0  <= r2_step ? '0 : n3_d0;
        r3_d1  <= r2_step ? '0 : n3_d1;
        r3_pos <= r2_pos;
    end

    // Stage 4: first Horner step of value and derivative.
    hse_horner_step u_val1 (
        .i_clk (i_clk),
        .i_acc (r3_c0),
        .i_pos (r3_pos),
        .i_add (r3_c1),
        .o_acc (acc1)
    );

    hse_horner_step u_der1 (
        .i_clk (i_clk),
        .i_acc (r3_d0),
        .i_pos (r3_pos),
        .i_add (r3_d1),
        .o_acc (der1)
    );

    always_ff @(posedge i_clk) begin
        r4_c2  <= r3_c2;
        r4_c3  <= r3_c3;
        r4_pos <= r3_pos;
    end

    // Stage 5: second step; the derivative is complete here.
    hse_horner_step u_val2 (
        .i_clk (i_clk),
        .i_acc (acc1),
        .i_pos (r4_pos),
        .i_add (r4_c2),
        .o_acc (acc2)
    );

    hse_horner_step u_der2 (
        .i_clk (i_clk),
        .i_acc (der1),
        .i_pos (r4_pos),
        .i_add (r4_c2),
        .o_acc (der2)
    );

    always_ff @(posedge i_clk) begin
        r5_c3  <= r4_c3;
        r5_pos <= r4_pos;
    end

    // Stage 6: last value step; hold the derivative alongside.
    hse_horner_step u_val3 (
        .i_clk (i_clk),
        .i_acc (acc2),
        .i_pos (r5_pos),
        .i_add (r5_c3),
        .o_acc (acc3)
    );

    always_ff @(posedge i_clk) begin
        r6_der <= der2;
    end

    // Stage 7: saturate to 32 bits into the output register.
    always_ff @(posedge i_clk) begin
        r7_value <= sat_val(acc3);
        r7_slope <= sat_val(r6_der);
    end

    assign o_done        = r_vld[STAGES-1];
    assign o_curve_value = r7_value;
    assign o_curve_slope = r7_slope;

endmodule

`default_nettype wire

FILE: hdl/hse_checker.sv
`default_nettype none

module hse_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic signed [31:0] i_start_value,
    input wire logic               i_step_mode,
    input wire logic [16:0]        i_position,
    input wire logic               o_done,
    input wire logic signed [31:0] o_curve_value,
    input wire logic signed [31:0] o_curve_slope
);

    // A result strobe always traces back to an earlier input transfer.
    a_done_has_item: assert property (@(posedge i_clk)
        o_done |-> ($past(start, 7) && !$past(busy, 7) && $past(i_rst_n, 7)))
        else $error("result strobe without a matching input transfer");

    // Reset drops everything in flight.
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    // Step mode holds the start value and gives a flat slope.
    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_step_mode, 7))
        |-> (o_curve_value == $past(i_start_value, 7) && o_curve_slope == 32'sd0))
        else $error("step mode result differs from start value");

    // At the start of the segment the value is the start key.
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_position, 7) == 17'd0)
        |-> (o_curve_value == $past(i_start_value, 7)))
        else $error("value at position zero differs from start value");

endmodule

bind hermite_segment_evaluate_core hse_checker u_hse_checker (.*);

`default_nettype wire
